### hdl/byte_stream_frame_splitter_assert.svh
// assertion macros for the byte stream frame splitter
// used by the top level; expects clk and arst_n in scope
`ifndef BYTE_STREAM_FRAME_SPLITTER_ASSERT_SVH
`define BYTE_STREAM_FRAME_SPLITTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BSFS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define BSFS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define BSFS_ASSERT_ALWAYS(lbl, cond, msg)
`define BSFS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hdl/bsfs_pkg.sv
// shared constants, register codes and control types of the frame splitter
// no dependencies
`timescale 1ns / 1ps
package bsfs_pkg;
	localparam int STORE_DEPTH = 64;
	localparam int DELIM_MAX = 4;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int FILL_W = $clog2(STORE_DEPTH + 1);
	localparam int RECENT_W = 8 * DELIM_MAX;
	localparam int LIM_W = 7;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [6:0] FRAME_LEN_RST = 7'd16;
	localparam logic [31:0] DELIM_RST = 32'h0000_000A;
	localparam logic [2:0] DELIM_CNT_RST = 3'd1;
	localparam logic [6:0] CACHE_LIMIT_RST = 7'd64;

	typedef enum logic [2:0] {
		REG_MODE = 3'd0,
		REG_FRAME_LEN = 3'd1,
		REG_DELIM = 3'd2,
		REG_DELIM_CNT = 3'd3,
		REG_CACHE_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic fixed_length_mode;
		logic [6:0] frame_length;
		logic [31:0] delimiter_bytes;
		logic [2:0] delimiter_count;
		logic [6:0] cache_limit;
	} cfg_t;

	typedef struct packed {
		logic step;
		logic issue;
	} ctrl_cmd_t;

	typedef struct packed {
		logic frame_done;
		logic rd_last;
		logic out_free;
	} dp_stat_t;
endpackage

### hdl/bsfs_if.sv
// request channel interfaces: incoming bytes and outgoing frame bytes
// no dependencies
`timescale 1ns / 1ps
interface bsfs_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] data_byte;
	modport source(output valid, output command, output data_byte, input ready);
	modport sink(input valid, input command, input data_byte, output ready);
endinterface

interface bsfs_out_if;
	logic valid;
	logic ready;
	logic [7:0] frame_byte;
	logic frame_last;
	modport source(output valid, output frame_byte, output frame_last, input ready);
	modport sink(input valid, input frame_byte, input frame_last, output ready);
endinterface

### hdl/bsfs_regs.sv
// configuration register file behind an apb-style port
// depends on bsfs_pkg
`timescale 1ns / 1ps
module bsfs_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [bsfs_pkg::PADDR_W-1:0] paddr,
	input logic [bsfs_pkg::PDATA_W-1:0] pwdata,
	output logic [bsfs_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output bsfs_pkg::cfg_t cfg
);
	bsfs_pkg::cfg_t cfg_q;
	bsfs_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = bsfs_pkg::reg_idx_t'(paddr[bsfs_pkg::PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fixed_length_mode <= 1'b0;
			cfg_q.frame_length <= bsfs_pkg::FRAME_LEN_RST;
			cfg_q.delimiter_bytes <= bsfs_pkg::DELIM_RST;
			cfg_q.delimiter_count <= bsfs_pkg::DELIM_CNT_RST;
			cfg_q.cache_limit <= bsfs_pkg::CACHE_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				bsfs_pkg::REG_MODE: cfg_q.fixed_length_mode <= pwdata[0];
				bsfs_pkg::REG_FRAME_LEN: cfg_q.frame_length <= pwdata[6:0];
				bsfs_pkg::REG_DELIM: cfg_q.delimiter_bytes <= pwdata[31:0];
				bsfs_pkg::REG_DELIM_CNT: cfg_q.delimiter_count <= pwdata[2:0];
				bsfs_pkg::REG_CACHE_LIMIT: cfg_q.cache_limit <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bsfs_pkg::REG_MODE: prdata = {31'd0, cfg_q.fixed_length_mode};
			bsfs_pkg::REG_FRAME_LEN: prdata = {25'd0, cfg_q.frame_length};
			bsfs_pkg::REG_DELIM: prdata = cfg_q.delimiter_bytes;
			bsfs_pkg::REG_DELIM_CNT: prdata = {29'd0, cfg_q.delimiter_count};
			bsfs_pkg::REG_CACHE_LIMIT: prdata = {25'd0, cfg_q.cache_limit};
			default: prdata = '0;
		endcase
	end
endmodule

### hdl/bsfs_dpath.sv
// datapath: frame store memory, fill count, recent bytes, frame detection, output register
// depends on bsfs_pkg
`timescale 1ns / 1ps
module bsfs_dpath (
	input logic clk,
	input logic arst_n,
	input bsfs_pkg::cfg_t cfg,
	input bsfs_pkg::ctrl_cmd_t cmd,
	input logic in_command,
	input logic [7:0] in_data,
	input logic out_ready,
	output bsfs_pkg::dp_stat_t stat,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic out_last
);
	localparam int LW = bsfs_pkg::LIM_W;
	localparam int FW = bsfs_pkg::FILL_W;
	localparam int RW = bsfs_pkg::RECENT_W;

	logic [7:0] mem [bsfs_pkg::STORE_DEPTH];
	logic [FW-1:0] fill_q;
	logic [RW-1:0] recent_q;
	logic [FW-1:0] rd_ptr_q;
	logic [FW-1:0] drain_len_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_last_q;

	logic [LW-1:0] limit;
	logic [LW-1:0] fill_ext;
	logic [LW-1:0] new_fill;
	logic [LW-1:0] len;
	logic [LW-1:0] dcnt;
	logic [RW-1:0] rec_new;
	logic [RW-1:0] mask;
	logic [RW-1:0] delim_ext;
	logic overflow;
	logic match;
	logic hit;
	logic store_byte;
	logic rd_last;

	always_comb begin
		limit = (cfg.cache_limit > LW'(bsfs_pkg::STORE_DEPTH)) ?
			LW'(bsfs_pkg::STORE_DEPTH) : cfg.cache_limit;
		fill_ext = LW'(fill_q);
		new_fill = fill_ext + 1'b1;
		overflow = fill_ext >= limit;
		rec_new = RW'({recent_q, in_data});
		len = (cfg.frame_length == '0) ? LW'(1) : cfg.frame_length;
		dcnt = (LW'(cfg.delimiter_count) > LW'(bsfs_pkg::DELIM_MAX)) ?
			LW'(bsfs_pkg::DELIM_MAX) : LW'(cfg.delimiter_count);
		for (int i = 0; i < bsfs_pkg::DELIM_MAX; i++) begin
			mask[i*8 +: 8] = (LW'(i) < dcnt) ? 8'hFF : 8'h00;
		end
		delim_ext = RW'(cfg.delimiter_bytes);
		match = ((rec_new ^ delim_ext) & mask) == '0;
		if (cfg.fixed_length_mode) begin
			hit = new_fill >= len;
		end else begin
			hit = (dcnt == '0) || ((new_fill >= dcnt) && match);
		end
		store_byte = cmd.step && !in_command && !overflow;
		rd_last = FW'(rd_ptr_q + 1'b1) == drain_len_q;
	end

	assign stat.frame_done = store_byte && hit;
	assign stat.rd_last = rd_last;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			recent_q <= '0;
			rd_ptr_q <= '0;
			drain_len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				if (!store_byte || hit) begin
					fill_q <= '0;
					recent_q <= '0;
				end else begin
					fill_q <= FW'(new_fill);
					recent_q <= rec_new;
				end
				if (store_byte && hit) begin
					drain_len_q <= FW'(new_fill);
					rd_ptr_q <= '0;
				end
			end
			if (cmd.issue) begin
				rd_ptr_q <= FW'(rd_ptr_q + 1'b1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// single write port, registered read into the output register
	always_ff @(posedge clk) begin
		if (store_byte) begin
			mem[fill_q[bsfs_pkg::ADDR_W-1:0]] <= in_data;
		end
		if (cmd.issue) begin
			out_byte_q <= mem[rd_ptr_q[bsfs_pkg::ADDR_W-1:0]];
			out_last_q <= rd_last;
		end
	end
endmodule

### hdl/bsfs_ctrl.sv
// controller: accepts requests while idle, sequences the frame drain
// depends on bsfs_pkg
`timescale 1ns / 1ps
module bsfs_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input bsfs_pkg::dp_stat_t stat,
	output logic in_ready,
	output bsfs_pkg::ctrl_cmd_t cmd
);
	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t state_q;

	assign in_ready = state_q == ST_IDLE;
	assign cmd.step = in_valid && in_ready;
	assign cmd.issue = (state_q == ST_DRAIN) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.step && stat.frame_done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.issue && stat.rd_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hdl/byte_stream_frame_splitter.sv
// byte stream frame splitter: one byte or clear request per cycle while idle
// a byte closing a frame stalls input while the single-port store is read out
// a byte a cycle unless frame_out stalls; first byte via drain state, output reg
// output register: the next request is taken with the last frame byte still waiting
// asynchronous active-low reset: registers to defaults, store empty, no clearing pass
// depends on bsfs_pkg, bsfs_if, bsfs_regs, bsfs_ctrl, bsfs_dpath and the assertion header
`timescale 1ns / 1ps
`include "byte_stream_frame_splitter_assert.svh"
module byte_stream_frame_splitter (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [bsfs_pkg::PADDR_W-1:0] paddr,
	input logic [bsfs_pkg::PDATA_W-1:0] pwdata,
	output logic [bsfs_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	bsfs_in_if.sink byte_in,
	bsfs_out_if.source frame_out
);
	bsfs_pkg::cfg_t cfg;
	bsfs_pkg::ctrl_cmd_t cmd;
	bsfs_pkg::dp_stat_t stat;
	logic in_ready;
	logic out_valid;
	logic [7:0] out_byte;
	logic out_last;

	assign byte_in.ready = in_ready;
	assign frame_out.valid = out_valid;
	assign frame_out.frame_byte = out_byte;
	assign frame_out.frame_last = out_last;

	bsfs_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	bsfs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(byte_in.valid),
		.stat(stat),
		.in_ready(in_ready),
		.cmd(cmd)
	);

	bsfs_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.in_command(byte_in.command),
		.in_data(byte_in.data_byte),
		.out_ready(frame_out.ready),
		.stat(stat),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.out_last(out_last)
	);

	`BSFS_ASSERT_NEXT(a_done_stalls, cmd.step && stat.frame_done, !byte_in.ready, "input not stalled after frame end")
	`BSFS_ASSERT_NEXT(a_last_flag, cmd.issue && stat.rd_last, frame_out.valid && frame_out.frame_last, "final frame byte lacks last flag")
	`BSFS_ASSERT_ALWAYS(a_no_overlap, !(cmd.step && cmd.issue), "request taken during drain")
endmodule

### tb/byte_stream_frame_splitter_test.sv
// self-checking bench for the byte stream frame splitter: apb set-up, byte requests in,
// frame bytes out, each checked against a local prediction of the splitting rules
// depends on bsfs_pkg, bsfs_if and byte_stream_frame_splitter
`timescale 1ns / 1ps
module byte_stream_frame_splitter_test;
	import bsfs_pkg::*;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 1000;

	typedef struct {
		logic command;
		logic [7:0] data_byte;
		bit drain_first;
	} byte_req_t;

	typedef struct {
		logic [7:0] frame_byte;
		logic frame_last;
	} frame_beat_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	bsfs_in_if byte_in();
	bsfs_out_if frame_out();

	byte_stream_frame_splitter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.byte_in(byte_in),
		.frame_out(frame_out)
	);

	// local copy of the splitter state and its registers
	cfg_t cfg_model;
	logic [7:0] frame_bytes [STORE_DEPTH];
	int unsigned fill;
	logic [RECENT_W-1:0] recent;

	byte_req_t byte_backlog [$];
	frame_beat_t expected_beats [$];
	byte_req_t next_req;
	frame_beat_t want;
	int in_gap;
	int out_gap;
	int stall_cycles;
	int errors;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic split_byte(input logic cmd, input logic [7:0] b);
		int unsigned lim;
		int unsigned len;
		int unsigned n;
		logic [RECENT_W-1:0] mask;
		logic done;
		done = 1'b0;
		if (cmd == CMD_CLEAR) begin
			fill = 0;
			recent = '0;
		end else begin
			lim = (cfg_model.cache_limit > STORE_DEPTH) ? STORE_DEPTH : cfg_model.cache_limit;
			if (fill >= lim) begin
				fill = 0;
				recent = '0;
			end else begin
				frame_bytes[fill] = b;
				fill++;
				recent = {recent[RECENT_W-9:0], b};
				if (cfg_model.fixed_length_mode) begin
					len = (cfg_model.frame_length == 0) ? 1 : cfg_model.frame_length;
					done = (fill >= len);
				end else begin
					n = cfg_model.delimiter_count;
					if (n == 0) begin
						done = 1'b1;
					end else begin
						if (n > DELIM_MAX)
							n = DELIM_MAX;
						if (fill >= n) begin
							mask = '0;
							for (int k = 0; k < n; k++)
								mask[8*k +: 8] = 8'hFF;
							done = ((recent & mask) == (cfg_model.delimiter_bytes & mask));
						end
					end
				end
				if (done) begin
					for (int i = 0; i < fill; i++)
						expected_beats.push_back('{frame_bytes[i], (i == fill - 1)});
					fill = 0;
					recent = '0;
				end
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_in.valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (byte_in.valid && byte_in.ready)
				split_byte(byte_in.command, byte_in.data_byte);
			if (byte_in.valid && !byte_in.ready) begin
			end else if (in_gap != 0) begin
				byte_in.valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (byte_backlog.size() != 0 &&
				!(byte_backlog[0].drain_first && expected_beats.size() != 0)) begin
				next_req = byte_backlog.pop_front();
				byte_in.valid <= 1'b1;
				byte_in.command <= next_req.command;
				byte_in.data_byte <= next_req.data_byte;
				if (!no_idle && $urandom_range(0, 7) == 0)
					in_gap <= $urandom_range(1, 10);
			end else begin
				byte_in.valid <= 1'b0;
			end
		end
	end

	// frame byte monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_out.ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (frame_out.valid && frame_out.ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: expected no frame byte, got byte %02h last %0b", $time,
						frame_out.frame_byte, frame_out.frame_last);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (frame_out.frame_byte !== want.frame_byte ||
						frame_out.frame_last !== want.frame_last) begin
						$display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
							$time, want.frame_byte, want.frame_last,
							frame_out.frame_byte, frame_out.frame_last);
						errors++;
					end
				end
			end
			if (out_gap != 0) begin
				frame_out.ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				frame_out.ready <= 1'b0;
				out_gap <= $urandom_range(0, 9);
			end else begin
				frame_out.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (byte_in.valid && byte_in.ready) ||
			(frame_out.valid && frame_out.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("FAIL byte_stream_frame_splitter");
		$finish;
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		case (idx)
			REG_MODE: cfg_model.fixed_length_mode = value[0];
			REG_FRAME_LEN: cfg_model.frame_length = value[6:0];
			REG_DELIM: cfg_model.delimiter_bytes = value;
			REG_DELIM_CNT: cfg_model.delimiter_count = value[2:0];
			REG_CACHE_LIMIT: cfg_model.cache_limit = value[6:0];
			default: ;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic queue_req(input logic cmd, input logic [7:0] b);
		byte_backlog.push_back('{cmd, b, ($urandom_range(0, 49) == 0)});
	endtask

	task automatic settle();
		while (byte_backlog.size() != 0 || byte_in.valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly delimiter-terminated frames in delimiter mode, plus stray bytes and clears
	task automatic queue_traffic(input int count, input int clear_pct);
		int added;
		int body;
		int n;
		int r;
		added = 0;
		while (added < count) begin
			r = $urandom_range(0, 99);
			if (r < clear_pct) begin
				queue_req(CMD_CLEAR, 8'($urandom_range(0, 255)));
				added++;
			end else if (!cfg_model.fixed_length_mode && r < 80) begin
				n = (cfg_model.delimiter_count > DELIM_MAX) ? DELIM_MAX : cfg_model.delimiter_count;
				body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
				for (int k = 0; k < body; k++)
					queue_req(CMD_APPEND, 8'($urandom_range(0, 255)));
				for (int k = n - 1; k >= 0; k--)
					queue_req(CMD_APPEND, cfg_model.delimiter_bytes[8*k +: 8]);
				added += body + n;
			end else begin
				queue_req(CMD_APPEND, 8'($urandom_range(0, 255)));
				added++;
			end
		end
	endtask

	task automatic pick_settings();
		logic [31:0] v;
		write_reg(REG_MODE, $urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 64;
			2: v = 127;
			default: v = $urandom_range(1, 16);
		endcase
		write_reg(REG_FRAME_LEN, v);
		case ($urandom_range(0, 9))
			0: v = 32'h0000_0000;
			1: v = 32'hFFFF_FFFF;
			2: v = DELIM_RST;
			default: v = $urandom;
		endcase
		write_reg(REG_DELIM, v);
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = $urandom_range(5, 7);
			default: v = $urandom_range(1, 4);
		endcase
		write_reg(REG_DELIM_CNT, v);
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = $urandom_range(65, 127);
			2: v = 64;
			default: v = $urandom_range(4, 64);
		endcase
		write_reg(REG_CACHE_LIMIT, v);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_in.valid = 1'b0;
		byte_in.command = CMD_APPEND;
		byte_in.data_byte = 8'h00;
		frame_out.ready = 1'b0;
		in_gap = 0;
		out_gap = 0;
		stall_cycles = 0;
		errors = 0;
		no_idle = 1'b0;
		cfg_model = '{1'b0, FRAME_LEN_RST, DELIM_RST, DELIM_CNT_RST, CACHE_LIMIT_RST};
		fill = 0;
		recent = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: newline delimiter closes a frame, then a clear with no bytes held
		queue_req(CMD_APPEND, 8'h00);
		queue_req(CMD_APPEND, 8'hFF);
		queue_req(CMD_APPEND, 8'h0A);
		queue_req(CMD_CLEAR, 8'hFF);
		queue_req(CMD_APPEND, 8'h0A);
		settle();
		// two-byte delimiter, first byte arrives before the store is long enough
		write_reg(REG_DELIM, 32'h0000_0D0A);
		write_reg(REG_DELIM_CNT, 2);
		queue_req(CMD_APPEND, 8'h0A);
		queue_req(CMD_APPEND, 8'h0D);
		queue_req(CMD_APPEND, 8'h0A);
		settle();
		// no delimiter: one-byte frames
		write_reg(REG_DELIM_CNT, 0);
		queue_req(CMD_APPEND, 8'h55);
		settle();
		// count above the maximum
		write_reg(REG_DELIM, 32'hDEAD_BEEF);
		write_reg(REG_DELIM_CNT, 7);
		queue_req(CMD_APPEND, 8'hDE);
		queue_req(CMD_APPEND, 8'hAD);
		queue_req(CMD_APPEND, 8'hBE);
		queue_req(CMD_APPEND, 8'hEF);
		settle();
		// fixed mode with zero length
		write_reg(REG_MODE, 1);
		write_reg(REG_FRAME_LEN, 0);
		queue_req(CMD_APPEND, 8'h12);
		settle();
		// zero cache limit drops every byte
		write_reg(REG_CACHE_LIMIT, 0);
		queue_req(CMD_APPEND, 8'h34);
		settle();
		// limit above the depth, then length lowered with bytes held
		write_reg(REG_CACHE_LIMIT, 100);
		write_reg(REG_FRAME_LEN, 5);
		queue_req(CMD_APPEND, 8'h01);
		queue_req(CMD_APPEND, 8'h02);
		queue_req(CMD_APPEND, 8'h03);
		settle();
		write_reg(REG_FRAME_LEN, 2);
		queue_req(CMD_APPEND, 8'h04);
		settle();

		// full-depth frames
		write_reg(REG_FRAME_LEN, 64);
		write_reg(REG_CACHE_LIMIT, 127);
		queue_traffic(130, 0);
		settle();

		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 11)
				no_idle = 1'b1;
			pick_settings();
			queue_traffic(24, 4);
			settle();
		end

		repeat (20) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$display("%0t: expected %0d more frame bytes, got none", $time, expected_beats.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS byte_stream_frame_splitter");
		else
			$display("FAIL byte_stream_frame_splitter");
		$finish;
	end
endmodule
